>>> rtl/core/src_pkg.sv
// Shared types and constants for the sensor round conditioner.
package src_pkg;

	// Width of one element on the shared scan datapath (covers a 17-bit pressure, signed).
	localparam int EL_W = 18;

	// Request codes carried by req_type.
	typedef enum logic [1:0] {
		REQ_AIR   = 2'd0,
		REQ_PRES  = 2'd1,
		REQ_WATER = 2'd2
	} req_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TRIM,
		ST_DIV,
		ST_DONE
	} state_t;

	// Channel currently on the shared unit.
	typedef enum logic [1:0] {
		CH_TEMP,
		CH_HUM,
		CH_PRES
	} chan_t;

	// Plausibility limits, hundredths of a degree or percent, pressure in pascal.
	localparam logic signed [15:0] AIR_T_LO   = -16'sd4000;
	localparam logic signed [15:0] AIR_T_HI   = 16'sd8500;
	localparam logic [13:0]        AIR_H_MAX  = 14'd10000;
	localparam logic [17:0]        PRES_LO    = 18'd30000;
	localparam logic [17:0]        PRES_HI    = 18'd120000;
	localparam logic signed [15:0] WAT_T_LO   = -16'sd5500;
	localparam logic signed [15:0] WAT_T_HI   = 16'sd12500;
	localparam logic signed [15:0] WAT_T_BAD  = 16'sd8500;
	localparam logic signed [14:0] HOLD_FLOOR = -15'sd5000;
	localparam logic [3:0]         HOLD_LIMIT_RST = 4'd3;

endpackage

>>> rtl/core/src_div.sv
// Serial restoring divider, one quotient bit per cycle.
module src_div
	import src_pkg::*;
#(
	parameter int NUM_W = 21,
	parameter int DEN_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// Shift in the next dividend bit and trial-subtract the divisor.
	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
	end

	// Control: iteration counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: the quotient fills in from the bottom as the dividend leaves the top.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/core/sensor_round_conditioner.sv
// Top level of the sensor round conditioner: sample stores, sequencer and result register.
//
//   Channel   Handshake              Moves
//   in        in_valid / in_stall    one request: air sample, pressure sample or water reading
//   out       out_valid / out_stall  one round result, produced per water reading
//   cfg       cfg_valid / cfg_ready  hold_limit write, ready is always high
//
// Air and pressure transactions are stored at once and do not stall the input. A water
// reading runs the round end on one shared add/compare unit and a serial divider that runs
// SW = 18 + clog2(AIR_SAMPLES) divider steps. in_stall is high from the water transaction
// until its result is loaded into the output register; the output register then holds the
// result under out_stall while new samples are taken. Reset is asynchronous, active low.
module sensor_round_conditioner
	import src_pkg::*;
#(
	parameter int AIR_SAMPLES = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	// Input request channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic               sample_ok,
	input  logic signed [15:0] temperature_centi,
	input  logic [13:0]        humidity_centi,
	input  logic [17:0]        pressure_pa,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] air_temp_out,
	output logic [13:0]        humidity_out,
	output logic               air_valid,
	output logic [16:0]        pressure_out,
	output logic               pressure_valid,
	output logic signed [14:0] water_temp_out,
	output logic               water_valid,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data
);

	localparam int CW   = $clog2(AIR_SAMPLES + 1);
	localparam int IW   = $clog2(AIR_SAMPLES);
	localparam int SW   = EL_W + $clog2(AIR_SAMPLES);
	localparam int DV_W = $clog2(AIR_SAMPLES);

	// Configuration and state.
	logic [3:0]         hold_limit_q;
	logic signed [14:0] held_q;
	logic [3:0]         hold_cnt_q;
	logic [CW-1:0]      air_cnt_q;
	logic [1:0]         p_cnt_q;
	state_t             state_q, state_d;
	chan_t              ch_q;
	logic [IW-1:0]      idx_q;

	// Sample stores.
	logic signed [14:0] at_store_q [AIR_SAMPLES];
	logic [13:0]        ah_store_q [AIR_SAMPLES];
	logic [16:0]        p_store_q  [3];

	// Working registers.
	logic signed [SW-1:0]   sum_q;
	logic signed [EL_W-1:0] lo_q, hi_q;
	logic                   neg_q;
	logic signed [14:0]     at_q;
	logic [13:0]            ah_q;
	logic [16:0]            pr_q;
	logic signed [14:0]     wt_q;
	logic                   wv_q;

	// Output register.
	logic               out_valid_q;
	logic signed [14:0] at_out_q;
	logic [13:0]        ah_out_q;
	logic               av_out_q;
	logic [16:0]        pr_out_q;
	logic               pv_out_q;
	logic signed [14:0] wt_out_q;
	logic               wv_out_q;

	// Handshake terms and sample checks.
	logic                   in_acc;
	logic                   air_keep, pres_keep, w_fresh, w_hold;
	logic                   out_free;
	logic signed [EL_W-1:0] el;
	logic [CW-1:0]          n_cur;
	logic                   scan_last;
	logic signed [SW-1:0]   num;
	logic [SW-1:0]          mag;
	logic [DV_W-1:0]        den;
	logic                   div_start, div_done;
	logic [SW-1:0]          quo;
	logic [SW-1:0]          res;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// Range checks on the incoming transaction.
	always_comb begin
		air_keep  = sample_ok && (temperature_centi > AIR_T_LO) &&
			(temperature_centi < AIR_T_HI) && (humidity_centi <= AIR_H_MAX) &&
			(air_cnt_q < CW'(AIR_SAMPLES));
		pres_keep = sample_ok && (pressure_pa > PRES_LO) && (pressure_pa < PRES_HI) &&
			(p_cnt_q != 2'd3);
		w_fresh   = sample_ok && (temperature_centi > WAT_T_LO) &&
			(temperature_centi < WAT_T_HI) && (temperature_centi != WAT_T_BAD);
		w_hold    = (held_q > HOLD_FLOOR) && (hold_cnt_q < hold_limit_q);
	end

	// Element selection and trim arithmetic for the channel on the shared unit.
	always_comb begin
		case (ch_q)
			CH_TEMP: el = EL_W'(at_store_q[idx_q]);
			CH_HUM:  el = signed'({4'b0, ah_store_q[idx_q]});
			default: el = signed'({1'b0, p_store_q[idx_q[1:0]]});
		endcase
		n_cur     = (ch_q == CH_PRES) ? CW'(p_cnt_q) : air_cnt_q;
		scan_last = (CW'(idx_q) + CW'(1)) == n_cur;
		num       = (n_cur >= CW'(3)) ? (sum_q - SW'(lo_q) - SW'(hi_q)) : sum_q;
		mag       = num[SW-1] ? unsigned'(-num) : unsigned'(num);
		den       = (n_cur >= CW'(3)) ? DV_W'(n_cur - CW'(2)) : DV_W'(n_cur);
		res       = neg_q ? (-quo) : quo;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider launch.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (req_type == REQ_WATER)) begin
					state_d = ((air_cnt_q != '0) || (p_cnt_q != 2'd0)) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (ch_q == CH_PRES) begin
					state_d = ST_DONE;
				end else begin
					state_d   = ST_DIV;
					div_start = 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ((ch_q == CH_TEMP) || (p_cnt_q != 2'd0)) ? ST_SCAN : ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers: counts, channel pointer, water hold and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_limit_q <= HOLD_LIMIT_RST;
			held_q       <= '0;
			hold_cnt_q   <= '0;
			air_cnt_q    <= '0;
			p_cnt_q      <= '0;
			ch_q         <= CH_TEMP;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			wv_q         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hold_limit_q <= cfg_data;
			end
			// A taken result clears the flag unless the next one loads in this cycle.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (req_type == REQ_AIR) && air_keep) begin
						air_cnt_q <= air_cnt_q + CW'(1);
					end
					if (in_acc && (req_type == REQ_PRES) && pres_keep) begin
						p_cnt_q <= p_cnt_q + 2'd1;
					end
					if (in_acc && (req_type == REQ_WATER)) begin
						ch_q  <= (air_cnt_q != '0) ? CH_TEMP : CH_PRES;
						idx_q <= '0;
						if (w_fresh) begin
							held_q     <= temperature_centi[14:0];
							hold_cnt_q <= '0;
							wv_q       <= 1'b1;
						end else if (w_hold) begin
							hold_cnt_q <= hold_cnt_q + 4'd1;
							wv_q       <= 1'b1;
						end else begin
							wv_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IW'(1);
				end
				ST_DIV: begin
					if (div_done) begin
						ch_q  <= (ch_q == CH_TEMP) ? CH_HUM : CH_PRES;
						idx_q <= '0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						air_cnt_q   <= '0;
						p_cnt_q     <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stores, shared accumulate/compare unit and round results.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (req_type == REQ_AIR) && air_keep) begin
					at_store_q[air_cnt_q[IW-1:0]] <= temperature_centi[14:0];
					ah_store_q[air_cnt_q[IW-1:0]] <= humidity_centi;
				end
				if (in_acc && (req_type == REQ_PRES) && pres_keep) begin
					p_store_q[p_cnt_q] <= pressure_pa[16:0];
				end
				if (in_acc && (req_type == REQ_WATER)) begin
					at_q <= '0;
					ah_q <= '0;
					pr_q <= '0;
					if (w_fresh) begin
						wt_q <= temperature_centi[14:0];
					end else if (w_hold) begin
						wt_q <= held_q;
					end else begin
						wt_q <= '0;
					end
				end
			end
			ST_SCAN: begin
				if (idx_q == '0) begin
					sum_q <= SW'(el);
					lo_q  <= el;
					hi_q  <= el;
				end else begin
					sum_q <= sum_q + SW'(el);
					lo_q  <= (el < lo_q) ? el : lo_q;
					hi_q  <= (el > hi_q) ? el : hi_q;
				end
			end
			ST_TRIM: begin
				neg_q <= num[SW-1];
				if (ch_q == CH_PRES) begin
					pr_q <= (p_cnt_q == 2'd3) ? num[16:0] : p_store_q[0];
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (ch_q == CH_TEMP) begin
						at_q <= res[14:0];
					end else begin
						ah_q <= res[13:0];
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					at_out_q <= at_q;
					ah_out_q <= ah_q;
					av_out_q <= (air_cnt_q != '0);
					pr_out_q <= pr_q;
					pv_out_q <= (p_cnt_q != 2'd0);
					wt_out_q <= wt_q;
					wv_out_q <= wv_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Shared serial divider for the air channel means.
	src_div #(
		.NUM_W(SW),
		.DEN_W(DV_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (mag),
		.den   (den),
		.done  (div_done),
		.quo   (quo)
	);

	// Result channel drive.
	assign out_valid      = out_valid_q;
	assign air_temp_out   = at_out_q;
	assign humidity_out   = ah_out_q;
	assign air_valid      = av_out_q;
	assign pressure_out   = pr_out_q;
	assign pressure_valid = pv_out_q;
	assign water_temp_out = wt_out_q;
	assign water_valid    = wv_out_q;

endmodule
